@@ hdl/rvd_pkg.sv @@
// Shared types and encoding constants for the RV64IM instruction decoder.
package rvd_pkg;

  localparam int INSTR_W = 32;
  localparam int OP_W    = 6;
  localparam int FMT_W   = 3;
  localparam int REG_W   = 5;
  localparam int IMM_W   = 20;

  // Major opcodes, instruction bits 6..2
  localparam logic [4:0] OPC_LOAD     = 5'b00000;
  localparam logic [4:0] OPC_OP_IMM   = 5'b00100;
  localparam logic [4:0] OPC_AUIPC    = 5'b00101;
  localparam logic [4:0] OPC_OP_IMM32 = 5'b00110;
  localparam logic [4:0] OPC_STORE    = 5'b01000;
  localparam logic [4:0] OPC_OP       = 5'b01100;
  localparam logic [4:0] OPC_LUI      = 5'b01101;
  localparam logic [4:0] OPC_OP32     = 5'b01110;
  localparam logic [4:0] OPC_BRANCH   = 5'b11000;
  localparam logic [4:0] OPC_JALR     = 5'b11001;
  localparam logic [4:0] OPC_JAL      = 5'b11011;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [5:0] F6_BASE   = 6'h00;
  localparam logic [5:0] F6_ALT    = 6'h10;

  typedef enum logic [FMT_W-1:0] {
    FMT_I       = 3'd0,
    FMT_R       = 3'd1,
    FMT_SHIFT64 = 3'd2,
    FMT_SHIFT32 = 3'd3,
    FMT_STORE   = 3'd4,
    FMT_BRANCH  = 3'd5,
    FMT_UJ      = 3'd6
  } fmt_t;

  typedef enum logic [OP_W-1:0] {
    OP_JALR, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_ADDI, OP_SLTI, OP_SLTIU,
    OP_XORI, OP_ORI, OP_ANDI, OP_LWU, OP_LD, OP_ADDIW,
    OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR,
    OP_AND, OP_ADDW, OP_SUBW, OP_SLLW, OP_SRLW, OP_SRAW, OP_MUL, OP_MULH,
    OP_MULHSU, OP_MULHU, OP_MULW, OP_DIV, OP_DIVU, OP_REM, OP_REMU, OP_DIVW,
    OP_SLLI, OP_SRLI, OP_SRAI,
    OP_SLLIW, OP_SRLIW, OP_SRAIW,
    OP_SB, OP_SH, OP_SW, OP_SD,
    OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
    OP_LUI, OP_AUIPC, OP_JAL
  } op_t;

  typedef struct packed {
    op_t              operation;
    fmt_t             format_class;
    logic             illegal;
    logic [REG_W-1:0] dest_reg;
    logic [REG_W-1:0] src1_reg;
    logic [REG_W-1:0] src2_reg;
    logic [IMM_W-1:0] immediate_bits;
  } decoded_t;

endpackage

@@ hdl/rvd_if.sv @@
// Valid/ready channel interfaces for instruction words and decoded results.
interface rvd_instr_if;
  logic                        valid;
  logic                        ready;
  logic [rvd_pkg::INSTR_W-1:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
  modport monitor (input valid, input instruction, input ready);
endinterface

interface rvd_decoded_if;
  logic                      valid;
  logic                      ready;
  logic [rvd_pkg::OP_W-1:0]  operation;
  logic [rvd_pkg::FMT_W-1:0] format_class;
  logic                      illegal;
  logic [rvd_pkg::REG_W-1:0] dest_reg;
  logic [rvd_pkg::REG_W-1:0] src1_reg;
  logic [rvd_pkg::REG_W-1:0] src2_reg;
  logic [rvd_pkg::IMM_W-1:0] immediate_bits;

  modport source (output valid, output operation, output format_class, output illegal,
                  output dest_reg, output src1_reg, output src2_reg,
                  output immediate_bits, input ready);
  modport sink (input valid, input operation, input format_class, input illegal,
                input dest_reg, input src1_reg, input src2_reg,
                input immediate_bits, output ready);
  modport monitor (input valid, input operation, input format_class, input illegal,
                   input dest_reg, input src1_reg, input src2_reg,
                   input immediate_bits, input ready);
endinterface

@@ hdl/rvd_in_stage.sv @@
// Input register stage: captures one instruction word per transfer.
module rvd_in_stage (
  input  logic                        clk,
  input  logic                        rst,
  rvd_instr_if.sink                   fetch,
  input  logic                        take,
  output logic                        valid,
  output logic [rvd_pkg::INSTR_W-1:0] instruction
);
  import rvd_pkg::*;

  // Refill whenever the held word leaves or the stage is empty; refuse transfers in reset.
  assign fetch.ready = !rst && (!valid || take);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (fetch.ready) begin
      valid <= fetch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch.valid && fetch.ready) begin
      instruction <= fetch.instruction;
    end
  end

endmodule

@@ hdl/rvd_decode.sv @@
// Combinational RV64IM table decode and immediate assembly.
module rvd_decode (
  input  logic [rvd_pkg::INSTR_W-1:0] instruction,
  output rvd_pkg::decoded_t           result
);
  import rvd_pkg::*;

  logic [4:0] opcode;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [5:0] f6;
  logic       hit;
  op_t        op;
  fmt_t       fmt;

  assign opcode = instruction[6:2];
  assign f3     = instruction[14:12];
  assign f7     = instruction[31:25];
  assign f6     = instruction[31:26];

  always_comb begin
    hit = 1'b1;
    op  = OP_JALR;
    fmt = FMT_I;
    case (opcode)
      OPC_JALR: begin
        hit = (f3 == 3'd0);
      end
      OPC_LOAD: begin
        case (f3)
          3'd0:    op = OP_LB;
          3'd1:    op = OP_LH;
          3'd2:    op = OP_LW;
          3'd3:    op = OP_LD;
          3'd4:    op = OP_LBU;
          3'd5:    op = OP_LHU;
          3'd6:    op = OP_LWU;
          default: hit = 1'b0;
        endcase
      end
      OPC_OP_IMM: begin
        case (f3)
          3'd0: op = OP_ADDI;
          3'd2: op = OP_SLTI;
          3'd3: op = OP_SLTIU;
          3'd4: op = OP_XORI;
          3'd6: op = OP_ORI;
          3'd7: op = OP_ANDI;
          3'd1: begin
            fmt = FMT_SHIFT64;
            op  = OP_SLLI;
            hit = (f6 == F6_BASE);
          end
          default: begin
            fmt = FMT_SHIFT64;
            op  = (f6 == F6_ALT) ? OP_SRAI : OP_SRLI;
            hit = (f6 == F6_BASE) || (f6 == F6_ALT);
          end
        endcase
      end
      OPC_OP_IMM32: begin
        fmt = FMT_SHIFT32;
        case (f3)
          3'd0: begin
            fmt = FMT_I;
            op  = OP_ADDIW;
          end
          3'd1: begin
            op  = OP_SLLIW;
            hit = (f7 == F7_BASE);
          end
          3'd5: begin
            op  = (f7 == F7_ALT) ? OP_SRAIW : OP_SRLIW;
            hit = (f7 == F7_BASE) || (f7 == F7_ALT);
          end
          default: hit = 1'b0;
        endcase
      end
      OPC_OP: begin
        fmt = FMT_R;
        case (f7)
          F7_BASE: begin
            case (f3)
              3'd0:    op = OP_ADD;
              3'd1:    op = OP_SLL;
              3'd2:    op = OP_SLT;
              3'd3:    op = OP_SLTU;
              3'd4:    op = OP_XOR;
              3'd5:    op = OP_SRL;
              3'd6:    op = OP_OR;
              default: op = OP_AND;
            endcase
          end
          F7_ALT: begin
            case (f3)
              3'd0:    op = OP_SUB;
              3'd5:    op = OP_SRA;
              default: hit = 1'b0;
            endcase
          end
          F7_MULDIV: begin
            case (f3)
              3'd0:    op = OP_MUL;
              3'd1:    op = OP_MULH;
              3'd2:    op = OP_MULHSU;
              3'd3:    op = OP_MULHU;
              3'd4:    op = OP_DIV;
              3'd5:    op = OP_DIVU;
              3'd6:    op = OP_REM;
              default: op = OP_REMU;
            endcase
          end
          default: hit = 1'b0;
        endcase
      end
      OPC_OP32: begin
        fmt = FMT_R;
        case (f7)
          F7_BASE: begin
            case (f3)
              3'd0:    op = OP_ADDW;
              3'd1:    op = OP_SLLW;
              3'd5:    op = OP_SRLW;
              default: hit = 1'b0;
            endcase
          end
          F7_ALT: begin
            case (f3)
              3'd0:    op = OP_SUBW;
              3'd5:    op = OP_SRAW;
              default: hit = 1'b0;
            endcase
          end
          F7_MULDIV: begin
            // divuw, remw and remuw are not supported
            case (f3)
              3'd0:    op = OP_MULW;
              3'd4:    op = OP_DIVW;
              default: hit = 1'b0;
            endcase
          end
          default: hit = 1'b0;
        endcase
      end
      OPC_STORE: begin
        fmt = FMT_STORE;
        case (f3)
          3'd0:    op = OP_SB;
          3'd1:    op = OP_SH;
          3'd2:    op = OP_SW;
          3'd3:    op = OP_SD;
          default: hit = 1'b0;
        endcase
      end
      OPC_BRANCH: begin
        fmt = FMT_BRANCH;
        case (f3)
          3'd0:    op = OP_BEQ;
          3'd1:    op = OP_BNE;
          3'd4:    op = OP_BLT;
          3'd5:    op = OP_BGE;
          3'd6:    op = OP_BLTU;
          3'd7:    op = OP_BGEU;
          default: hit = 1'b0;
        endcase
      end
      OPC_LUI: begin
        fmt = FMT_UJ;
        op  = OP_LUI;
      end
      OPC_AUIPC: begin
        fmt = FMT_UJ;
        op  = OP_AUIPC;
      end
      OPC_JAL: begin
        fmt = FMT_UJ;
        op  = OP_JAL;
      end
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    result = '0;
    if (!hit) begin
      result.illegal = 1'b1;
    end else begin
      result.operation    = op;
      result.format_class = fmt;
      if (fmt inside {FMT_I, FMT_R, FMT_SHIFT64, FMT_SHIFT32, FMT_UJ}) begin
        result.dest_reg = instruction[11:7];
      end
      if (fmt != FMT_UJ) begin
        result.src1_reg = instruction[19:15];
      end
      if (fmt inside {FMT_R, FMT_STORE, FMT_BRANCH}) begin
        result.src2_reg = instruction[24:20];
      end
      case (fmt)
        FMT_I:       result.immediate_bits = {8'd0, instruction[31:20]};
        FMT_SHIFT64: result.immediate_bits = {14'd0, instruction[25:20]};
        FMT_SHIFT32: result.immediate_bits = {15'd0, instruction[24:20]};
        FMT_STORE:   result.immediate_bits = {8'd0, instruction[31:25], instruction[11:7]};
        FMT_BRANCH:  result.immediate_bits = {8'd0, instruction[31], instruction[7],
                                              instruction[30:25], instruction[11:8]};
        FMT_UJ: begin
          if (op == OP_JAL) begin
            result.immediate_bits = {instruction[31], instruction[19:12],
                                     instruction[20], instruction[30:21]};
          end else begin
            result.immediate_bits = instruction[31:12];
          end
        end
        default:     result.immediate_bits = '0;
      endcase
    end
  end

endmodule

@@ hdl/rvd_out_stage.sv @@
// Result register stage: holds one decoded result until its transfer.
module rvd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  rvd_pkg::decoded_t result,
  output logic              take,
  rvd_decoded_if.source     decoded
);
  import rvd_pkg::*;

  logic     valid;
  decoded_t held;

  assign take = !valid || decoded.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      held <= result;
    end
  end

  assign decoded.valid          = valid;
  assign decoded.operation      = held.operation;
  assign decoded.format_class   = held.format_class;
  assign decoded.illegal        = held.illegal;
  assign decoded.dest_reg       = held.dest_reg;
  assign decoded.src1_reg       = held.src1_reg;
  assign decoded.src2_reg       = held.src2_reg;
  assign decoded.immediate_bits = held.immediate_bits;

endmodule

@@ hdl/rv64im_instruction_decoder.sv @@
// RV64IM decoder: input register, table decode, result register.
// An instruction goes through the input register, then the result register.
// Throughput: one instruction per cycle unless stalled; both stages refill when drained.
// A stalled result stage holds its item while the input stage takes one more.
// Reset (rst, synchronous) empties both stages; fetch.ready stays low while rst is high.
module rv64im_instruction_decoder (
  input  logic        clk,
  input  logic        rst,
  rvd_instr_if.sink   fetch,
  rvd_decoded_if.source decoded
);
  import rvd_pkg::*;

  logic                 stage_valid;
  logic [INSTR_W-1:0]   stage_instruction;
  logic                 take;
  decoded_t             result;

  rvd_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .fetch       (fetch),
    .take        (take),
    .valid       (stage_valid),
    .instruction (stage_instruction)
  );

  rvd_decode u_decode (
    .instruction (stage_instruction),
    .result      (result)
  );

  rvd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stage_valid),
    .result   (result),
    .take     (take),
    .decoded  (decoded)
  );

endmodule

@@ hdl/rvd_checker.sv @@
// Port-level checks for the RV64IM decoder and their bind to the top level.
module rvd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      fetch_ready,
  input logic                      decoded_valid,
  input logic                      decoded_ready,
  input logic [rvd_pkg::OP_W-1:0]  operation,
  input logic [rvd_pkg::FMT_W-1:0] format_class,
  input logic                      illegal,
  input logic [rvd_pkg::REG_W-1:0] dest_reg,
  input logic [rvd_pkg::REG_W-1:0] src1_reg,
  input logic [rvd_pkg::REG_W-1:0] src2_reg,
  input logic [rvd_pkg::IMM_W-1:0] immediate_bits
);
  import rvd_pkg::*;

  // An illegal result carries nothing else.
  a_illegal_clean: assert property (@(posedge clk) disable iff (rst)
    decoded_valid && illegal |->
      operation == '0 && format_class == '0 &&
      dest_reg == '0 && src1_reg == '0 &&
      src2_reg == '0 && immediate_bits == '0)
    else $error("illegal result with nonzero fields");

  // R-type results have no immediate and an index in the R range.
  a_r_format: assert property (@(posedge clk) disable iff (rst)
    decoded_valid && !illegal && format_class == FMT_R |->
      immediate_bits == '0 && operation >= OP_ADD &&
      operation <= OP_DIVW)
    else $error("R-type result inconsistent");

  // Upper/jump results never name source registers.
  a_uj_regs: assert property (@(posedge clk) disable iff (rst)
    decoded_valid && !illegal && format_class == FMT_UJ |->
      src1_reg == '0 && src2_reg == '0 &&
      operation >= OP_LUI)
    else $error("upper/jump result inconsistent");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    decoded_valid && !decoded_ready |=>
      decoded_valid && $stable(operation) && $stable(immediate_bits))
    else $error("stalled result changed");

  // Refuse input during reset and come out of it empty.
  a_reset_quiet: assert property (@(posedge clk)
    rst |-> !fetch_ready ##1 !decoded_valid)
    else $error("transfer possible or result valid around reset");

endmodule

bind rv64im_instruction_decoder rvd_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .fetch_ready    (fetch.ready),
  .decoded_valid  (decoded.valid),
  .decoded_ready  (decoded.ready),
  .operation      (decoded.operation),
  .format_class   (decoded.format_class),
  .illegal        (decoded.illegal),
  .dest_reg       (decoded.dest_reg),
  .src1_reg       (decoded.src1_reg),
  .src2_reg       (decoded.src2_reg),
  .immediate_bits (decoded.immediate_bits)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for the RV64IM instruction decoder.
module tb_top;
  import rvd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 8;
  localparam int RANDOM_ITEMS = 320;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rvd_instr_if   fetch_ch ();
  rvd_decoded_if decoded_ch ();

  rv64im_instruction_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .fetch   (fetch_ch),
    .decoded (decoded_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  decoded_t pending_decodes[$];
  int       mismatch_count = 0;
  int       cycle_count    = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;

  // Expected decode of one instruction word.
  function automatic decoded_t decode_word(input logic [31:0] w);
    decoded_t   d;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [5:0] f6;
    logic       hit;
    d   = '0;
    f3  = w[14:12];
    f7  = w[31:25];
    f6  = w[31:26];
    hit = 1'b1;
    case (w[6:2])
      OPC_JALR: begin
        if (f3 == 3'd0) d.operation = OP_JALR;
        else hit = 1'b0;
      end
      OPC_LOAD: begin
        case (f3)
          3'd0: d.operation = OP_LB;
          3'd1: d.operation = OP_LH;
          3'd2: d.operation = OP_LW;
          3'd3: d.operation = OP_LD;
          3'd4: d.operation = OP_LBU;
          3'd5: d.operation = OP_LHU;
          3'd6: d.operation = OP_LWU;
          default: hit = 1'b0;
        endcase
      end
      OPC_OP_IMM: begin
        case (f3)
          3'd0: d.operation = OP_ADDI;
          3'd2: d.operation = OP_SLTI;
          3'd3: d.operation = OP_SLTIU;
          3'd4: d.operation = OP_XORI;
          3'd6: d.operation = OP_ORI;
          3'd7: d.operation = OP_ANDI;
          3'd1: begin
            d.format_class = FMT_SHIFT64;
            if (f6 == F6_BASE) d.operation = OP_SLLI;
            else hit = 1'b0;
          end
          default: begin
            d.format_class = FMT_SHIFT64;
            if (f6 == F6_BASE) d.operation = OP_SRLI;
            else if (f6 == F6_ALT) d.operation = OP_SRAI;
            else hit = 1'b0;
          end
        endcase
      end
      OPC_OP_IMM32: begin
        if (f3 == 3'd0) begin
          d.operation = OP_ADDIW;
        end else begin
          d.format_class = FMT_SHIFT32;
          if (f3 == 3'd1 && f7 == F7_BASE) d.operation = OP_SLLIW;
          else if (f3 == 3'd5 && f7 == F7_BASE) d.operation = OP_SRLIW;
          else if (f3 == 3'd5 && f7 == F7_ALT) d.operation = OP_SRAIW;
          else hit = 1'b0;
        end
      end
      OPC_OP: begin
        d.format_class = FMT_R;
        case (f7)
          F7_BASE: begin
            case (f3)
              3'd0: d.operation = OP_ADD;
              3'd1: d.operation = OP_SLL;
              3'd2: d.operation = OP_SLT;
              3'd3: d.operation = OP_SLTU;
              3'd4: d.operation = OP_XOR;
              3'd5: d.operation = OP_SRL;
              3'd6: d.operation = OP_OR;
              default: d.operation = OP_AND;
            endcase
          end
          F7_ALT: begin
            if (f3 == 3'd0) d.operation = OP_SUB;
            else if (f3 == 3'd5) d.operation = OP_SRA;
            else hit = 1'b0;
          end
          F7_MULDIV: begin
            case (f3)
              3'd0: d.operation = OP_MUL;
              3'd1: d.operation = OP_MULH;
              3'd2: d.operation = OP_MULHSU;
              3'd3: d.operation = OP_MULHU;
              3'd4: d.operation = OP_DIV;
              3'd5: d.operation = OP_DIVU;
              3'd6: d.operation = OP_REM;
              default: d.operation = OP_REMU;
            endcase
          end
          default: hit = 1'b0;
        endcase
      end
      OPC_OP32: begin
        d.format_class = FMT_R;
        // divuw, remw and remuw are not supported
        if (f7 == F7_BASE && f3 == 3'd0) d.operation = OP_ADDW;
        else if (f7 == F7_BASE && f3 == 3'd1) d.operation = OP_SLLW;
        else if (f7 == F7_BASE && f3 == 3'd5) d.operation = OP_SRLW;
        else if (f7 == F7_ALT && f3 == 3'd0) d.operation = OP_SUBW;
        else if (f7 == F7_ALT && f3 == 3'd5) d.operation = OP_SRAW;
        else if (f7 == F7_MULDIV && f3 == 3'd0) d.operation = OP_MULW;
        else if (f7 == F7_MULDIV && f3 == 3'd4) d.operation = OP_DIVW;
        else hit = 1'b0;
      end
      OPC_STORE: begin
        d.format_class = FMT_STORE;
        case (f3)
          3'd0: d.operation = OP_SB;
          3'd1: d.operation = OP_SH;
          3'd2: d.operation = OP_SW;
          3'd3: d.operation = OP_SD;
          default: hit = 1'b0;
        endcase
      end
      OPC_BRANCH: begin
        d.format_class = FMT_BRANCH;
        case (f3)
          3'd0: d.operation = OP_BEQ;
          3'd1: d.operation = OP_BNE;
          3'd4: d.operation = OP_BLT;
          3'd5: d.operation = OP_BGE;
          3'd6: d.operation = OP_BLTU;
          3'd7: d.operation = OP_BGEU;
          default: hit = 1'b0;
        endcase
      end
      OPC_LUI: begin
        d.format_class = FMT_UJ;
        d.operation    = OP_LUI;
      end
      OPC_AUIPC: begin
        d.format_class = FMT_UJ;
        d.operation    = OP_AUIPC;
      end
      OPC_JAL: begin
        d.format_class = FMT_UJ;
        d.operation    = OP_JAL;
      end
      default: hit = 1'b0;
    endcase

    if (!hit) begin
      d         = '0;
      d.illegal = 1'b1;
      return d;
    end

    if (d.format_class inside {FMT_I, FMT_R, FMT_SHIFT64, FMT_SHIFT32, FMT_UJ})
      d.dest_reg = w[11:7];
    if (d.format_class != FMT_UJ)
      d.src1_reg = w[19:15];
    if (d.format_class inside {FMT_R, FMT_STORE, FMT_BRANCH})
      d.src2_reg = w[24:20];
    case (d.format_class)
      FMT_I:       d.immediate_bits = 20'(w[31:20]);
      FMT_SHIFT64: d.immediate_bits = 20'(w[25:20]);
      FMT_SHIFT32: d.immediate_bits = 20'(w[24:20]);
      FMT_STORE:   d.immediate_bits = 20'({w[31:25], w[11:7]});
      FMT_BRANCH:  d.immediate_bits = 20'({w[31], w[7], w[30:25], w[11:8]});
      FMT_UJ: begin
        if (d.operation == OP_JAL)
          d.immediate_bits = {w[31], w[19:12], w[20], w[30:21]};
        else
          d.immediate_bits = w[31:12];
      end
      default:     d.immediate_bits = '0;
    endcase
    return d;
  endfunction

  // Build a word for the given operation; fields it does not fix come from fill.
  function automatic logic [31:0] encode_op(input op_t op, input logic [31:0] fill);
    logic [31:0] w;
    logic [4:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic        fix7;
    logic        fix6;
    opc  = OPC_LOAD;
    f3   = fill[14:12];
    f7   = F7_BASE;
    fix7 = 1'b0;
    fix6 = 1'b0;
    case (op)
      OP_JALR:   begin opc = OPC_JALR;     f3 = 3'd0; end
      OP_LB:     begin opc = OPC_LOAD;     f3 = 3'd0; end
      OP_LH:     begin opc = OPC_LOAD;     f3 = 3'd1; end
      OP_LW:     begin opc = OPC_LOAD;     f3 = 3'd2; end
      OP_LBU:    begin opc = OPC_LOAD;     f3 = 3'd4; end
      OP_LHU:    begin opc = OPC_LOAD;     f3 = 3'd5; end
      OP_ADDI:   begin opc = OPC_OP_IMM;   f3 = 3'd0; end
      OP_SLTI:   begin opc = OPC_OP_IMM;   f3 = 3'd2; end
      OP_SLTIU:  begin opc = OPC_OP_IMM;   f3 = 3'd3; end
      OP_XORI:   begin opc = OPC_OP_IMM;   f3 = 3'd4; end
      OP_ORI:    begin opc = OPC_OP_IMM;   f3 = 3'd6; end
      OP_ANDI:   begin opc = OPC_OP_IMM;   f3 = 3'd7; end
      OP_LWU:    begin opc = OPC_LOAD;     f3 = 3'd6; end
      OP_LD:     begin opc = OPC_LOAD;     f3 = 3'd3; end
      OP_ADDIW:  begin opc = OPC_OP_IMM32; f3 = 3'd0; end
      OP_ADD:    begin opc = OPC_OP;   f3 = 3'd0; f7 = F7_BASE;   fix7 = 1'b1; end
      OP_SUB:    begin opc = OPC_OP;   f3 = 3'd0; f7 = F7_ALT;    fix7 = 1'b1; end
      OP_SLL:    begin opc = OPC_OP;   f3 = 3'd1; f7 = F7_BASE;   fix7 = 1'b1; end
      OP_SLT:    begin opc = OPC_OP;   f3 = 3'd2; f7 = F7_BASE;   fix7 = 1'b1; end
      OP_SLTU:   begin opc = OPC_OP;   f3 = 3'd3; f7 = F7_BASE;   fix7 = 1'b1; end
      OP_XOR:    begin opc = OPC_OP;   f3 = 3'd4; f7 = F7_BASE;   fix7 = 1'b1; end
      OP_SRL:    begin opc = OPC_OP;   f3 = 3'd5; f7 = F7_BASE;   fix7 = 1'b1; end
      OP_SRA:    begin opc = OPC_OP;   f3 = 3'd5; f7 = F7_ALT;    fix7 = 1'b1; end
      OP_OR:     begin opc = OPC_OP;   f3 = 3'd6; f7 = F7_BASE;   fix7 = 1'b1; end
      OP_AND:    begin opc = OPC_OP;   f3 = 3'd7; f7 = F7_BASE;   fix7 = 1'b1; end
      OP_ADDW:   begin opc = OPC_OP32; f3 = 3'd0; f7 = F7_BASE;   fix7 = 1'b1; end
      OP_SUBW:   begin opc = OPC_OP32; f3 = 3'd0; f7 = F7_ALT;    fix7 = 1'b1; end
      OP_SLLW:   begin opc = OPC_OP32; f3 = 3'd1; f7 = F7_BASE;   fix7 = 1'b1; end
      OP_SRLW:   begin opc = OPC_OP32; f3 = 3'd5; f7 = F7_BASE;   fix7 = 1'b1; end
      OP_SRAW:   begin opc = OPC_OP32; f3 = 3'd5; f7 = F7_ALT;    fix7 = 1'b1; end
      OP_MUL:    begin opc = OPC_OP;   f3 = 3'd0; f7 = F7_MULDIV; fix7 = 1'b1; end
      OP_MULH:   begin opc = OPC_OP;   f3 = 3'd1; f7 = F7_MULDIV; fix7 = 1'b1; end
      OP_MULHSU: begin opc = OPC_OP;   f3 = 3'd2; f7 = F7_MULDIV; fix7 = 1'b1; end
      OP_MULHU:  begin opc = OPC_OP;   f3 = 3'd3; f7 = F7_MULDIV; fix7 = 1'b1; end
      OP_MULW:   begin opc = OPC_OP32; f3 = 3'd0; f7 = F7_MULDIV; fix7 = 1'b1; end
      OP_DIV:    begin opc = OPC_OP;   f3 = 3'd4; f7 = F7_MULDIV; fix7 = 1'b1; end
      OP_DIVU:   begin opc = OPC_OP;   f3 = 3'd5; f7 = F7_MULDIV; fix7 = 1'b1; end
      OP_REM:    begin opc = OPC_OP;   f3 = 3'd6; f7 = F7_MULDIV; fix7 = 1'b1; end
      OP_REMU:   begin opc = OPC_OP;   f3 = 3'd7; f7 = F7_MULDIV; fix7 = 1'b1; end
      OP_DIVW:   begin opc = OPC_OP32; f3 = 3'd4; f7 = F7_MULDIV; fix7 = 1'b1; end
      OP_SLLI:   begin opc = OPC_OP_IMM; f3 = 3'd1; f7 = {F6_BASE, 1'b0}; fix6 = 1'b1; end
      OP_SRLI:   begin opc = OPC_OP_IMM; f3 = 3'd5; f7 = {F6_BASE, 1'b0}; fix6 = 1'b1; end
      OP_SRAI:   begin opc = OPC_OP_IMM; f3 = 3'd5; f7 = {F6_ALT, 1'b0};  fix6 = 1'b1; end
      OP_SLLIW:  begin opc = OPC_OP_IMM32; f3 = 3'd1; f7 = F7_BASE; fix7 = 1'b1; end
      OP_SRLIW:  begin opc = OPC_OP_IMM32; f3 = 3'd5; f7 = F7_BASE; fix7 = 1'b1; end
      OP_SRAIW:  begin opc = OPC_OP_IMM32; f3 = 3'd5; f7 = F7_ALT;  fix7 = 1'b1; end
      OP_SB:     begin opc = OPC_STORE;  f3 = 3'd0; end
      OP_SH:     begin opc = OPC_STORE;  f3 = 3'd1; end
      OP_SW:     begin opc = OPC_STORE;  f3 = 3'd2; end
      OP_SD:     begin opc = OPC_STORE;  f3 = 3'd3; end
      OP_BEQ:    begin opc = OPC_BRANCH; f3 = 3'd0; end
      OP_BNE:    begin opc = OPC_BRANCH; f3 = 3'd1; end
      OP_BLT:    begin opc = OPC_BRANCH; f3 = 3'd4; end
      OP_BGE:    begin opc = OPC_BRANCH; f3 = 3'd5; end
      OP_BLTU:   begin opc = OPC_BRANCH; f3 = 3'd6; end
      OP_BGEU:   begin opc = OPC_BRANCH; f3 = 3'd7; end
      OP_LUI:    opc = OPC_LUI;
      OP_AUIPC:  opc = OPC_AUIPC;
      default:   opc = OPC_JAL;
    endcase
    w        = fill;
    w[6:2]   = opc;
    w[14:12] = f3;
    if (fix7) w[31:25] = f7;
    if (fix6) w[31:26] = f7[6:1];
    return w;
  endfunction

  // Mostly well-formed words with random content; the rest near misses and noise.
  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    int          pick;
    int          idx;
    int          pos;
    pick = $urandom_range(99);
    w    = encode_op(op_t'($urandom_range(int'(OP_JAL))), $urandom());
    if (pick >= 90) begin
      w = $urandom();
    end else if (pick >= 75) begin
      // flip one opcode, funct3 or funct7 bit
      idx = $urandom_range(14);
      if (idx < 5) pos = 2 + idx;
      else if (idx < 8) pos = 12 + idx - 5;
      else pos = 25 + idx - 8;
      w[pos] = ~w[pos];
    end
    return w;
  endfunction

  task automatic send_instruction(input logic [31:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      fetch_ch.valid <= 1'b0;
    end
    @(negedge clk);
    fetch_ch.valid       <= 1'b1;
    fetch_ch.instruction <= word;
    do @(posedge clk); while (fetch_ch.ready !== 1'b1);
    pending_decodes.push_back(decode_word(word));
  endtask

  // Drop valid, then hold until every expected result has been seen.
  task automatic wait_for_decodes();
    @(negedge clk);
    fetch_ch.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic send_random_batch(input int count);
    for (int i = 0; i < count; i++) send_instruction(random_instruction());
  endtask

  task automatic test_directed_encodings();
    logic [31:0] words[] = '{
      32'h0000_0000,
      32'hFFFF_FFFF,
      {12'hFFF, 5'd31, 3'd0, 5'd31, OPC_JALR, 2'b11},
      {12'h000, 5'd1, 3'd1, 5'd1, OPC_JALR, 2'b11},
      {12'h800, 5'd31, 3'd0, 5'd31, OPC_OP_IMM32, 2'b10},
      {F6_ALT, 6'd63, 5'd31, 3'd5, 5'd31, OPC_OP_IMM, 2'b11},
      {F6_BASE, 6'd32, 5'd0, 3'd1, 5'd0, OPC_OP_IMM, 2'b11},
      {6'h01, 6'd5, 5'd3, 3'd5, 5'd4, OPC_OP_IMM, 2'b11},
      {F7_ALT, 5'd31, 5'd31, 3'd5, 5'd31, OPC_OP_IMM32, 2'b11},
      {7'h01, 5'd0, 5'd2, 3'd1, 5'd2, OPC_OP_IMM32, 2'b11},
      {F7_MULDIV, 5'd5, 5'd6, 3'd5, 5'd7, OPC_OP32, 2'b11},
      {F7_MULDIV, 5'd5, 5'd6, 3'd6, 5'd7, OPC_OP32, 2'b11},
      {F7_MULDIV, 5'd5, 5'd6, 3'd7, 5'd7, OPC_OP32, 2'b11},
      {F7_MULDIV, 5'd31, 5'd0, 3'd4, 5'd31, OPC_OP32, 2'b11},
      {F7_ALT, 5'd31, 5'd31, 3'd0, 5'd31, OPC_OP, 2'b11},
      {F7_ALT, 5'd1, 5'd1, 3'd1, 5'd1, OPC_OP, 2'b11},
      {7'h7F, 5'd31, 5'd31, 3'd3, 5'd31, OPC_STORE, 2'b11},
      {7'h00, 5'd0, 5'd0, 3'd0, 5'd0, OPC_STORE, 2'b11},
      {7'h00, 5'd0, 5'd0, 3'd4, 5'd0, OPC_STORE, 2'b11},
      {7'h7F, 5'd31, 5'd31, 3'd7, 5'd31, OPC_BRANCH, 2'b11},
      {1'b1, 6'd0, 5'd0, 5'd0, 3'd0, 4'd0, 1'b1, OPC_BRANCH, 2'b11},
      {7'h00, 5'd0, 5'd0, 3'd2, 5'd0, OPC_BRANCH, 2'b11},
      {20'hFFFFF, 5'd31, OPC_JAL, 2'b11},
      {20'hFFFFF, 5'd0, OPC_LUI, 2'b00},
      {20'h80000, 5'd31, OPC_AUIPC, 2'b01},
      {12'h000, 5'd0, 3'd7, 5'd0, OPC_LOAD, 2'b11}
    };
    foreach (words[i]) send_instruction(words[i]);
  endtask

  task automatic test_every_operation();
    for (int i = 0; i <= int'(OP_JAL); i++) send_instruction(encode_op(op_t'(i), $urandom()));
  endtask

  task automatic test_random_no_idle();
    set_idling(0, 0);
    send_random_batch(RANDOM_ITEMS);
  endtask

  task automatic test_random_sender_idle();
    set_idling(68, 0);
    send_random_batch(RANDOM_ITEMS);
  endtask

  task automatic test_random_receiver_stall();
    set_idling(0, 68);
    send_random_batch(RANDOM_ITEMS);
  endtask

  task automatic test_random_both_idle();
    set_idling(12, 12);
    send_random_batch(RANDOM_ITEMS);
  endtask

  task automatic check_field(input string name, input logic [19:0] want,
                             input logic [19:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every result transfer against the oldest expected decode.
  always @(posedge clk) begin
    decoded_t want;
    if (!rst && decoded_ch.valid === 1'b1 && decoded_ch.ready === 1'b1) begin
      if (pending_decodes.size() == 0) begin
        $error("decoded result with no instruction outstanding");
        mismatch_count++;
      end else begin
        want = pending_decodes.pop_front();
        check_field("operation", 20'(want.operation), 20'(decoded_ch.operation));
        check_field("format_class", 20'(want.format_class), 20'(decoded_ch.format_class));
        check_field("illegal", 20'(want.illegal), 20'(decoded_ch.illegal));
        check_field("dest_reg", 20'(want.dest_reg), 20'(decoded_ch.dest_reg));
        check_field("src1_reg", 20'(want.src1_reg), 20'(decoded_ch.src1_reg));
        check_field("src2_reg", 20'(want.src2_reg), 20'(decoded_ch.src2_reg));
        check_field("immediate_bits", want.immediate_bits, decoded_ch.immediate_bits);
      end
    end
  end

  always @(negedge clk) begin
    decoded_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    fetch_ch.valid       = 1'b0;
    fetch_ch.instruction = '0;
    decoded_ch.ready     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_encodings();
    test_every_operation();
    // hold off until the pipeline has drained completely
    wait_for_decodes();
    test_random_no_idle();
    test_random_sender_idle();
    wait_for_decodes();
    test_random_receiver_stall();
    test_random_both_idle();

    @(negedge clk);
    fetch_ch.valid <= 1'b0;
    set_idling(0, 0);
    wait_for_decodes();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatch_count == 0 && pending_decodes.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
hdl/rvd_pkg.sv
hdl/rvd_if.sv
hdl/rvd_in_stage.sv
hdl/rvd_decode.sv
hdl/rvd_out_stage.sv
hdl/rv64im_instruction_decoder.sv
hdl/rvd_checker.sv
dv/tb_top.sv
